// ===== hdl/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Checksummed frame receiver package
// Shared types, codes and constants for the frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'hFA;
    localparam logic [BYTE_W-1:0] BUS_ID_BYTE   = 8'hFF;

    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_ENABLE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_ID     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_LENGTH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_ENABLE    = 2'd3;

    localparam logic [BYTE_W-1:0] RST_EXPECTED_ID     = 8'd54;
    localparam logic [BYTE_W-1:0] RST_EXPECTED_LENGTH = 8'd30;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_BUS  = 3'd1,
        PH_ID   = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_SUM  = 3'd5
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_END_GOOD = 2'd1,
        KIND_END_BAD  = 2'd2
    } t_kind;

    typedef struct packed {
        logic              filter_enable;
        logic [BYTE_W-1:0] expected_id;
        logic [BYTE_W-1:0] expected_length;
        logic              check_enable;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] frame_id;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] frame_length;
    } t_result;

endpackage

// ===== hdl/cfr_if.sv =====
// ----------------------------------------------------------------------------
// Frame receiver channel interfaces
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface cfr_byte_if;
    logic                       valid;
    logic                       ready;
    logic [cfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_result_if;
    logic                       valid;
    logic                       ready;
    logic [cfr_pkg::KIND_W-1:0] kind;
    logic [cfr_pkg::BYTE_W-1:0] frame_id;
    logic [cfr_pkg::BYTE_W-1:0] payload_byte;
    logic [cfr_pkg::BYTE_W-1:0] byte_index;
    logic [cfr_pkg::BYTE_W-1:0] frame_length;

    modport source (output valid, output kind, output frame_id, output payload_byte,
                    output byte_index, output frame_length, input ready);
    modport sink   (input valid, input kind, input frame_id, input payload_byte,
                    input byte_index, input frame_length, output ready);
endinterface

// ===== hdl/checksummed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Checksummed frame receiver
// Finds preamble/bus id/id/length/payload/checksum frames in a byte stream.
//
//   Channel   Direction  Transaction
//   i_rx      in         one received byte (rx_byte)
//   o_res     out        one payload byte or one frame end result
//   i_cfg_*   in         register write, no handshake
//
// One byte is taken per clock while the output register is free; a byte's result
// appears in the cycle after it is taken. The frame state and running sum update as
// the byte is taken, so the rate is set only by the output register: a byte is taken
// whenever that register is empty or drained in the same cycle. Synchronous reset
// clears the frame state, the output register and the configuration registers.
// ----------------------------------------------------------------------------
module checksummed_frame_receiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cfr_byte_if.sink                        i_rx,
    cfr_result_if.source                    o_res,
    input  logic                            i_cfg_we,
    input  logic [cfr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [cfr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    cfr_pkg::t_cfg    r_cfg;
    logic             r_out_valid, n_out_valid;
    cfr_pkg::t_result r_out;
    logic             accept;
    logic             res_valid;
    cfr_pkg::t_result res;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;

    cfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_rx.rx_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_enable   <= 1'b0;
            r_cfg.expected_id     <= cfr_pkg::RST_EXPECTED_ID;
            r_cfg.expected_length <= cfr_pkg::RST_EXPECTED_LENGTH;
            r_cfg.check_enable    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cfr_pkg::CFG_FILTER_ENABLE:   r_cfg.filter_enable   <= i_cfg_data[0];
                cfr_pkg::CFG_EXPECTED_ID:     r_cfg.expected_id     <= i_cfg_data;
                cfr_pkg::CFG_EXPECTED_LENGTH: r_cfg.expected_length <= i_cfg_data;
                cfr_pkg::CFG_CHECK_ENABLE:    r_cfg.check_enable    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (accept) begin
            n_out_valid = res_valid;
        end else begin
            n_out_valid = r_out_valid && !o_res.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_out.kind;
    assign o_res.frame_id     = r_out.frame_id;
    assign o_res.payload_byte = r_out.payload_byte;
    assign o_res.byte_index   = r_out.byte_index;
    assign o_res.frame_length = r_out.frame_length;

endmodule

// ===== hdl/cfr_parser.sv =====
// ----------------------------------------------------------------------------
// Frame parser
// Byte-wide frame state machine with running checksum; one byte per accept.
// ----------------------------------------------------------------------------
module cfr_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [cfr_pkg::BYTE_W-1:0] i_byte,
    input  cfr_pkg::t_cfg              i_cfg,
    output logic                       o_res_valid,
    output cfr_pkg::t_result           o_res
);

    cfr_pkg::t_phase             r_phase, n_phase;
    logic [cfr_pkg::BYTE_W-1:0]  r_id, n_id;
    logic [cfr_pkg::BYTE_W-1:0]  r_len, n_len;
    logic [cfr_pkg::BYTE_W-1:0]  r_count, n_count;
    logic [cfr_pkg::BYTE_W-1:0]  r_sum, n_sum;
    logic [cfr_pkg::BYTE_W-1:0]  sum_plus;
    logic [cfr_pkg::BYTE_W-1:0]  count_plus;
    logic                        id_reject;
    logic                        len_reject;
    cfr_pkg::t_phase             drop_phase;

    assign sum_plus   = r_sum + i_byte;
    assign count_plus = r_count + 8'd1;
    assign id_reject  = i_cfg.filter_enable && (i_byte != i_cfg.expected_id);
    assign len_reject = i_cfg.filter_enable && (i_byte != i_cfg.expected_length);
    assign drop_phase = (i_byte == cfr_pkg::PREAMBLE_BYTE) ? cfr_pkg::PH_BUS
                                                            : cfr_pkg::PH_HUNT;

    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            unique case (r_phase)
                cfr_pkg::PH_HUNT: n_phase = drop_phase;
                cfr_pkg::PH_BUS: begin
                    n_phase = (i_byte == cfr_pkg::BUS_ID_BYTE) ? cfr_pkg::PH_ID : drop_phase;
                end
                cfr_pkg::PH_ID: n_phase = id_reject ? drop_phase : cfr_pkg::PH_LEN;
                cfr_pkg::PH_LEN: begin
                    if (len_reject) begin
                        n_phase = drop_phase;
                    end else if (i_byte == '0) begin
                        n_phase = cfr_pkg::PH_SUM;
                    end else begin
                        n_phase = cfr_pkg::PH_DATA;
                    end
                end
                cfr_pkg::PH_DATA: begin
                    n_phase = (count_plus == r_len) ? cfr_pkg::PH_SUM : cfr_pkg::PH_DATA;
                end
                cfr_pkg::PH_SUM: n_phase = cfr_pkg::PH_HUNT;
                default: n_phase = drop_phase;
            endcase
        end
    end

    always_comb begin
        n_id                = r_id;
        n_len               = r_len;
        n_count             = r_count;
        n_sum               = r_sum;
        o_res_valid         = 1'b0;
        o_res.kind          = cfr_pkg::KIND_PAYLOAD;
        o_res.frame_id      = r_id;
        o_res.payload_byte  = '0;
        o_res.byte_index    = '0;
        o_res.frame_length  = r_len;
        if (i_accept) begin
            unique case (r_phase)
                cfr_pkg::PH_BUS: begin
                    if (i_byte == cfr_pkg::BUS_ID_BYTE) begin
                        n_sum = cfr_pkg::BUS_ID_BYTE;
                    end
                end
                cfr_pkg::PH_ID: begin
                    if (!id_reject) begin
                        n_id  = i_byte;
                        n_sum = sum_plus;
                    end
                end
                cfr_pkg::PH_LEN: begin
                    if (!len_reject) begin
                        n_len   = i_byte;
                        n_sum   = sum_plus;
                        n_count = '0;
                    end
                end
                cfr_pkg::PH_DATA: begin
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = i_byte;
                    o_res.byte_index   = r_count;
                    n_sum              = sum_plus;
                    n_count            = count_plus;
                end
                cfr_pkg::PH_SUM: begin
                    o_res_valid = 1'b1;
                    n_sum       = sum_plus;
                    o_res.kind  = ((sum_plus == '0) || !i_cfg.check_enable)
                                  ? cfr_pkg::KIND_END_GOOD : cfr_pkg::KIND_END_BAD;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cfr_pkg::PH_HUNT;
            r_id    <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_id    <= n_id;
            r_len   <= n_len;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

endmodule

// ===== hdl/cfr_checker.sv =====
// ----------------------------------------------------------------------------
// Frame receiver port checker
// Concurrent assertions on the top-level ports, bound to the receiver.
// ----------------------------------------------------------------------------
module cfr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [cfr_pkg::KIND_W-1:0] i_kind,
    input logic [cfr_pkg::BYTE_W-1:0] i_frame_id,
    input logic [cfr_pkg::BYTE_W-1:0] i_payload_byte,
    input logic [cfr_pkg::BYTE_W-1:0] i_byte_index,
    input logic [cfr_pkg::BYTE_W-1:0] i_frame_length
);

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_kind == cfr_pkg::KIND_PAYLOAD) ||
                        (i_kind == cfr_pkg::KIND_END_GOOD) ||
                        (i_kind == cfr_pkg::KIND_END_BAD))
        else $error("Result transaction carries an undefined kind.");

    a_end_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_kind != cfr_pkg::KIND_PAYLOAD))
            |-> (i_payload_byte == '0) && (i_byte_index == '0))
        else $error("Frame end result carries a nonzero byte or index.");

    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_kind == cfr_pkg::KIND_PAYLOAD)) |-> (i_byte_index < i_frame_length))
        else $error("Payload index is not below the frame length.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_out_valid) |-> i_in_ready)
        else $error("Input stalled while no result is pending.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_kind) &&
            $stable(i_frame_id) && $stable(i_payload_byte) &&
            $stable(i_byte_index) && $stable(i_frame_length))
        else $error("Stalled result transaction changed.");

endmodule

bind checksummed_frame_receiver cfr_checker u_cfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_rx.valid),
    .i_in_ready     (i_rx.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_kind         (o_res.kind),
    .i_frame_id     (o_res.frame_id),
    .i_payload_byte (o_res.payload_byte),
    .i_byte_index   (o_res.byte_index),
    .i_frame_length (o_res.frame_length)
);

// ===== test/checksummed_frame_receiver_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Checksummed frame receiver testbench
// Streams good, corrupt, filtered and broken frames through the receiver
// under several register settings. Both channels idle at random in all but the last
// setting. A built-in frame parser predicts each payload byte and frame end, and every
// result transaction is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module checksummed_frame_receiver_test;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned DRAIN_LIMIT   = 200_000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned LONG_HOLD_AT  = 60;
    localparam int unsigned MAX_REPORTS   = 50;

    typedef logic [cfr_pkg::BYTE_W-1:0] t_byte;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [cfr_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [cfr_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    cfr_byte_if   rx_ch ();
    cfr_result_if res_ch ();

    checksummed_frame_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    cfr_pkg::t_cfg   shadow_cfg;
    cfr_pkg::t_phase parse_phase;
    t_byte           frame_id_q;
    t_byte           frame_len_q;
    t_byte           payload_pos;
    t_byte           frame_sum;

    t_byte             bytes_to_send [$];
    cfr_pkg::t_result  awaited_results [$];

    int unsigned send_mode       = 1;
    int unsigned recv_mode       = 1;
    int unsigned send_idle       = 0;
    int unsigned recv_idle       = 0;
    int unsigned bytes_queued    = 0;
    int unsigned bytes_taken     = 0;
    int unsigned results_checked = 0;
    int unsigned payloads_seen   = 0;
    int unsigned good_ends       = 0;
    int unsigned bad_ends        = 0;
    int unsigned reg_writes      = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    function automatic int unsigned draw_gap(input int unsigned mode);
        int unsigned r;
        if (mode == 0) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 65) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic cfr_pkg::t_phase resume_hunt(input t_byte b);
        return (b == cfr_pkg::PREAMBLE_BYTE) ? cfr_pkg::PH_BUS : cfr_pkg::PH_HUNT;
    endfunction

    function automatic logic parse_byte(input t_byte b, output cfr_pkg::t_result res);
        parse_byte = 1'b0;
        res        = '0;
        case (parse_phase)
            cfr_pkg::PH_BUS: begin
                if (b == cfr_pkg::BUS_ID_BYTE) begin
                    frame_sum   = cfr_pkg::BUS_ID_BYTE;
                    parse_phase = cfr_pkg::PH_ID;
                end else begin
                    parse_phase = resume_hunt(b);
                end
            end
            cfr_pkg::PH_ID: begin
                if (shadow_cfg.filter_enable && b != shadow_cfg.expected_id) begin
                    parse_phase = resume_hunt(b);
                end else begin
                    frame_id_q  = b;
                    frame_sum   = frame_sum + b;
                    parse_phase = cfr_pkg::PH_LEN;
                end
            end
            cfr_pkg::PH_LEN: begin
                if (shadow_cfg.filter_enable && b != shadow_cfg.expected_length) begin
                    parse_phase = resume_hunt(b);
                end else begin
                    frame_len_q = b;
                    frame_sum   = frame_sum + b;
                    payload_pos = '0;
                    parse_phase = (b == '0) ? cfr_pkg::PH_SUM : cfr_pkg::PH_DATA;
                end
            end
            cfr_pkg::PH_DATA: begin
                res.kind         = cfr_pkg::KIND_PAYLOAD;
                res.frame_id     = frame_id_q;
                res.payload_byte = b;
                res.byte_index   = payload_pos;
                res.frame_length = frame_len_q;
                frame_sum        = frame_sum + b;
                payload_pos      = payload_pos + 1'b1;
                if (payload_pos == frame_len_q) begin
                    parse_phase = cfr_pkg::PH_SUM;
                end
                parse_byte = 1'b1;
            end
            cfr_pkg::PH_SUM: begin
                frame_sum        = frame_sum + b;
                res.kind         = (frame_sum == '0 || !shadow_cfg.check_enable) ?
                                   cfr_pkg::KIND_END_GOOD : cfr_pkg::KIND_END_BAD;
                res.frame_id     = frame_id_q;
                res.frame_length = frame_len_q;
                parse_phase      = cfr_pkg::PH_HUNT;
                parse_byte       = 1'b1;
            end
            default: begin
                parse_phase = resume_hunt(b);
            end
        endcase
    endfunction

    // Sender side: a byte is held until taken, then the next one follows after a random gap that may be empty.
    always @(posedge i_clk) begin : drive_bytes
        cfr_pkg::t_result prediction;
        logic             next_valid;
        t_byte            next_byte;
        if (!i_rst_n) begin
            rx_ch.valid <= 1'b0;
            send_idle   = 0;
            parse_phase = cfr_pkg::PH_HUNT;
            frame_id_q  = '0;
            frame_len_q = '0;
            payload_pos = '0;
            frame_sum   = '0;
            shadow_cfg  = '{filter_enable: 1'b0, expected_id: cfr_pkg::RST_EXPECTED_ID,
                            expected_length: cfr_pkg::RST_EXPECTED_LENGTH,
                            check_enable: 1'b1};
        end else if (!rx_ch.valid || rx_ch.ready) begin
            if (rx_ch.valid) begin
                bytes_taken++;
                if (parse_byte(rx_ch.rx_byte, prediction)) begin
                    awaited_results.push_back(prediction);
                end
            end
            next_valid = 1'b0;
            next_byte  = rx_ch.rx_byte;
            if (send_idle > 0) begin
                send_idle--;
            end else if (bytes_to_send.size() > 0) begin
                next_valid = 1'b1;
                next_byte  = bytes_to_send.pop_front();
                send_idle  = draw_gap(send_mode);
            end
            rx_ch.valid   <= next_valid;
            rx_ch.rx_byte <= next_byte;
        end
    end

    task automatic compare_field(input string name, input t_byte got, input t_byte want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: expected %02h, got %02h",
                                      results_checked, name, want, got));
        end
    endtask

    // Receiver side: checks each transaction and applies its own stalls.
    always @(posedge i_clk) begin : check_results
        cfr_pkg::t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            recv_idle    = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_checked));
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("kind", {6'd0, res_ch.kind}, {6'd0, want.kind});
                    compare_field("frame_id", res_ch.frame_id, want.frame_id);
                    compare_field("payload_byte", res_ch.payload_byte, want.payload_byte);
                    compare_field("byte_index", res_ch.byte_index, want.byte_index);
                    compare_field("frame_length", res_ch.frame_length, want.frame_length);
                    case (want.kind)
                        cfr_pkg::KIND_PAYLOAD:  payloads_seen++;
                        cfr_pkg::KIND_END_GOOD: good_ends++;
                        default:                bad_ends++;
                    endcase
                end
                results_checked++;
                if (results_checked == LONG_HOLD_AT) begin
                    recv_idle = LONG_HOLD;
                end
            end
            if (recv_idle > 0) begin
                recv_idle--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                recv_idle = draw_gap(recv_mode);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic queue_byte(input t_byte b);
        bytes_to_send.push_back(b);
        bytes_queued++;
    endtask

    // A negative fill gives random payload bytes.
    task automatic queue_frame(input t_byte id, input t_byte len,
                               input logic corrupt, input int fill);
        t_byte sum;
        t_byte pb;
        t_byte check;
        sum = cfr_pkg::BUS_ID_BYTE + id + len;
        queue_byte(cfr_pkg::PREAMBLE_BYTE);
        queue_byte(cfr_pkg::BUS_ID_BYTE);
        queue_byte(id);
        queue_byte(len);
        for (int i = 0; i < len; i++) begin
            pb  = (fill < 0) ? t_byte'($urandom_range(255)) : fill[cfr_pkg::BYTE_W-1:0];
            sum = sum + pb;
            queue_byte(pb);
        end
        check = 8'd0 - sum;
        if (corrupt) begin
            check = check ^ (8'd1 << $urandom_range(7));
        end
        queue_byte(check);
    endtask

    task automatic random_traffic(input int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned n;
        t_byte       id;
        t_byte       len;
        stop_at = bytes_queued + budget;
        while (bytes_queued < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                if (shadow_cfg.filter_enable && $urandom_range(9) < 8) begin
                    id = shadow_cfg.expected_id;
                end else begin
                    id = t_byte'($urandom_range(255));
                end
                if (shadow_cfg.filter_enable && $urandom_range(9) < 8) begin
                    len = shadow_cfg.expected_length;
                end else if ($urandom_range(49) == 0) begin
                    len = t_byte'($urandom_range(255));
                end else begin
                    len = t_byte'($urandom_range(8));
                end
                queue_frame(id, len, $urandom_range(3) == 0, -1);
            end else if (pick < 86) begin
                queue_byte(cfr_pkg::PREAMBLE_BYTE);
                queue_byte(($urandom_range(1) == 0) ? cfr_pkg::BUS_ID_BYTE
                                                    : t_byte'($urandom_range(255)));
                n = $urandom_range(2);
                repeat (n) queue_byte(t_byte'($urandom_range(255)));
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    queue_byte(($urandom_range(3) == 0) ? cfr_pkg::PREAMBLE_BYTE
                                                        : t_byte'($urandom_range(255)));
                end
            end
        end
    endtask

    task automatic settle();
        int unsigned waited;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while ((bytes_to_send.size() != 0 || rx_ch.valid || awaited_results.size() != 0)
                   && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [cfr_pkg::CFG_INDEX_W-1:0] index,
                           input logic [cfr_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        case (index)
            cfr_pkg::CFG_FILTER_ENABLE:   shadow_cfg.filter_enable   = value[0];
            cfr_pkg::CFG_EXPECTED_ID:     shadow_cfg.expected_id     = value;
            cfr_pkg::CFG_EXPECTED_LENGTH: shadow_cfg.expected_length = value;
            cfr_pkg::CFG_CHECK_ENABLE:    shadow_cfg.check_enable    = value[0];
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic filt, input t_byte id_v,
                             input t_byte len_v, input logic chk,
                             input int unsigned stalls, input int unsigned budget);
        settle();
        set_reg(cfr_pkg::CFG_FILTER_ENABLE, {7'd0, filt});
        set_reg(cfr_pkg::CFG_EXPECTED_ID, id_v);
        set_reg(cfr_pkg::CFG_EXPECTED_LENGTH, len_v);
        set_reg(cfr_pkg::CFG_CHECK_ENABLE, {7'd0, chk});
        send_mode = stalls;
        recv_mode = stalls;
        random_traffic(budget);
    endtask

    initial begin : stimulus
        t_byte check;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Noise, a wrong bus id, a doubled preamble, a zero-length and a corrupt one-byte frame.
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(cfr_pkg::PREAMBLE_BYTE);
        queue_byte(8'h00);
        queue_byte(cfr_pkg::PREAMBLE_BYTE);
        queue_frame(8'h00, 8'h00, 1'b0, 0);
        queue_frame(8'hFF, 8'h01, 1'b1, 255);

        // The length is checked against the register value when the length byte arrives.
        queue_byte(cfr_pkg::PREAMBLE_BYTE);
        queue_byte(cfr_pkg::BUS_ID_BYTE);
        queue_byte(cfr_pkg::RST_EXPECTED_ID);
        settle();
        set_reg(cfr_pkg::CFG_FILTER_ENABLE, 8'd1);
        set_reg(cfr_pkg::CFG_EXPECTED_LENGTH, 8'd1);
        check = 8'd0 - cfr_pkg::BUS_ID_BYTE - cfr_pkg::RST_EXPECTED_ID - 8'd1;
        queue_byte(8'h01);
        queue_byte(8'h00);
        queue_byte(check);

        // A filtered id that is itself a preamble, then a filtered length.
        queue_byte(cfr_pkg::PREAMBLE_BYTE);
        queue_byte(cfr_pkg::BUS_ID_BYTE);
        queue_byte(cfr_pkg::PREAMBLE_BYTE);
        queue_byte(cfr_pkg::BUS_ID_BYTE);
        queue_byte(cfr_pkg::RST_EXPECTED_ID);
        queue_byte(8'h00);

        run_phase(1'b0, 8'd0, 8'd0, 1'b1, 1, 260);
        run_phase(1'b1, 8'd255, 8'd0, 1'b1, 1, 220);
        run_phase(1'b0, 8'd255, 8'd255, 1'b0, 1, 220);
        run_phase(1'b1, 8'd0, 8'd255, 1'b0, 1, 100);
        run_phase(1'b1, t_byte'($urandom_range(255)), t_byte'($urandom_range(1, 6)),
                  1'b1, 1, 250);
        run_phase(1'b0, t_byte'($urandom_range(255)), t_byte'($urandom_range(255)),
                  1'b1, 0, 280);
        settle();

        if (awaited_results.size() != 0 || bytes_to_send.size() != 0 || rx_ch.valid) begin
            report_mismatch($sformatf("%0d results never arrived, %0d bytes never taken",
                                      awaited_results.size(), bytes_to_send.size()));
        end
        $display("Sent %0d bytes over eight register settings, %0d register writes.",
                 bytes_taken, reg_writes);
        $display("Checked %0d payload bytes, %0d good and %0d bad frame ends, %0d errors.",
                 payloads_seen, good_ends, bad_ends, error_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/cfr_pkg.sv
hdl/cfr_if.sv
hdl/cfr_parser.sv
hdl/checksummed_frame_receiver.sv
hdl/cfr_checker.sv
test/checksummed_frame_receiver_test.sv
